/* hw/rtl/ufbf_pkg.sv */
`default_nettype none

package ufbf_pkg;

  localparam int unsigned MAX_IMAGE_BYTES_DEF = 65536;

  localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
  localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
  localparam logic [31:0] FLAGS_FAMILY = 32'h0000_2000;
  localparam logic [31:0] PAYLOAD_SIZE = 32'h0000_0100;
  localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;
  localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

  localparam int unsigned HEADER_WORDS  = 8;
  localparam int unsigned PAYLOAD_WORDS = 64;
  localparam int unsigned FILL_WORDS    = 55;

  localparam logic [5:0] LAST_PAYLOAD = 6'(PAYLOAD_WORDS - 1);
  localparam logic [5:0] CRC_WORD     = 6'(PAYLOAD_WORDS - 1);
  localparam logic [5:0] LAST_HEADER  = 6'(HEADER_WORDS - 1);
  localparam logic [5:0] LAST_FILL    = 6'(FILL_WORDS - 1);

  localparam logic [16:0] IMAGE_BYTES_RESET  = 17'h1_0000;
  localparam logic [31:0] BASE_ADDRESS_RESET = 32'h1000_0000;
  localparam logic [31:0] FAMILY_ID_RESET    = 32'hE48B_FF56;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef enum logic [1:0] {
    REG_IMAGE_BYTES  = 2'd0,
    REG_BASE_ADDRESS = 2'd1,
    REG_FAMILY_ID    = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    BK_HEAD,
    BK_PAY,
    BK_FILL,
    BK_END,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h000000};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/uf2_block_framer_with_boot_crc.sv */
// Frames a flash image into UF2 blocks of 128 output words each.
// The image arrives on the input channel as one 32-bit little-endian word per
// handshake; every 64 input words make one block of header, payload, zero fill
// and end magic on the output channel, which carries one word per handshake.
// The block count, zero masking of bytes past the image length and the
// header fields follow the APB registers image_bytes, base_address and
// family_id, which the user must write only while the framer is idle; the
// block does not enforce this. An input word reaches the output through the
// queue and the output register, and the first word of a block is preceded
// by its eight header words. The output side emits one word per cycle unless
// the receiver or an empty queue holds it; input is taken while the queue
// has room. During block 0 the boot CRC is updated one byte per cycle, so
// each of the first 63 input words holds the input side until its bytes are
// folded in. A two-word queue separates the input side from the output
// sequencer, and a single output register holds the word on offer until the
// receiver takes it. When the receiver stalls, the output word holds and the
// queue fills; the input side then deasserts ready. After the last payload
// word of the final block all further input words are accepted and discarded
// until reset. Reset is asynchronous and active low; it restores the register
// defaults, clears the block and word counters and loads the CRC with all ones.
`default_nettype none

module uf2_block_framer_with_boot_crc
  import ufbf_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] image_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_word_o,
  output logic             end_of_block_o,
  output logic             end_of_image_o
);

  localparam int unsigned LEN_W      = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int unsigned CMP_W      = ((LEN_W > 17) ? LEN_W : 17) + 1;
  localparam int unsigned BLOCKS_MAX = (MAX_IMAGE_BYTES + 255) / 256;
  localparam int unsigned CNT_W      = $clog2(BLOCKS_MAX + 1);

  logic [16:0] image_bytes_q;
  logic [31:0] base_address_q;
  logic [31:0] family_id_q;

  logic             wr_en;
  reg_idx_e         reg_idx;
  logic [CMP_W-1:0] img_ext;
  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] blocks_full;
  logic [CNT_W-1:0] blocks;

  logic         push;
  logic [31:0]  push_word;
  logic         pop;
  logic [31:0]  pop_word;
  fifo_status_t fifo_status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (reg_idx)
      REG_IMAGE_BYTES:  prdata = 32'(image_bytes_q);
      REG_BASE_ADDRESS: prdata = base_address_q;
      REG_FAMILY_ID:    prdata = family_id_q;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_bytes_q  <= IMAGE_BYTES_RESET;
      base_address_q <= BASE_ADDRESS_RESET;
      family_id_q    <= FAMILY_ID_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_BYTES:  image_bytes_q  <= pwdata[16:0];
        REG_BASE_ADDRESS: base_address_q <= pwdata;
        REG_FAMILY_ID:    family_id_q    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  assign img_ext = CMP_W'(image_bytes_q);
  assign len = (image_bytes_q == '0) ? CMP_W'(1) :
               (img_ext > CMP_W'(MAX_IMAGE_BYTES)) ? CMP_W'(MAX_IMAGE_BYTES) : img_ext;
  assign blocks_full = (len + CMP_W'(255)) >> 8;
  assign blocks      = blocks_full[CNT_W-1:0];

  ufbf_front #(
    .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .image_word_i (image_word_i),
    .len_i        (len),
    .blocks_i     (blocks),
    .push_o       (push),
    .push_word_o  (push_word),
    .fifo_i       (fifo_status)
  );

  ufbf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .pop_word_o  (pop_word),
    .status_o    (fifo_status)
  );

  ufbf_back #(
    .MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_o          (pop),
    .pop_word_i     (pop_word),
    .fifo_i         (fifo_status),
    .blocks_i       (blocks),
    .base_address_i (base_address_q),
    .family_id_i    (family_id_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_word_o     (out_word_o),
    .end_of_block_o (end_of_block_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/ufbf_fifo.sv */
`default_nettype none

module ufbf_fifo
  import ufbf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [31:0]  push_word_i,
  input  wire logic         pop_i,
  output logic [31:0]       pop_word_o,
  output fifo_status_t      status_o
);

  logic [31:0]           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign status_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_word_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ufbf_front.sv */
`default_nettype none

module ufbf_front
  import ufbf_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF,
  localparam int unsigned LEN_W      = $clog2(MAX_IMAGE_BYTES + 1),
  localparam int unsigned CMP_W      = ((LEN_W > 17) ? LEN_W : 17) + 1,
  localparam int unsigned BLOCKS_MAX = (MAX_IMAGE_BYTES + 255) / 256,
  localparam int unsigned CNT_W      = $clog2(BLOCKS_MAX + 1),
  localparam int unsigned BN_W       = (BLOCKS_MAX > 1) ? $clog2(BLOCKS_MAX) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [31:0]      image_word_i,
  input  wire logic [CMP_W-1:0] len_i,
  input  wire logic [CNT_W-1:0] blocks_i,
  output logic                  push_o,
  output logic [31:0]           push_word_o,
  input  fifo_status_t          fifo_i
);

  logic [5:0]      wib_q, wib_d;
  logic [BN_W-1:0] blk_q, blk_d;
  logic [31:0]     crc_q, crc_d;
  logic            done_q, done_d;
  logic            busy_q, busy_d;
  logic [1:0]      idx_q, idx_d;
  logic [31:0]     hold_q;

  logic             accept;
  logic [CMP_W-1:0] byte_base;
  logic [31:0]      masked;
  logic             last_blk;
  logic             first_blk;

  assign in_ready_o = !busy_q && (done_q || !fifo_i.full);
  assign accept     = in_valid_i && in_ready_o;
  assign first_blk  = (blk_q == '0);
  assign byte_base  = CMP_W'({blk_q, 8'h00}) + CMP_W'({wib_q, 2'b00});
  assign last_blk   = ((CNT_W + 1)'(blk_q) + 1'b1) >= (CNT_W + 1)'(blocks_i);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      masked[8*k +: 8] = ((byte_base + CMP_W'(k)) < len_i) ? image_word_i[8*k +: 8] : 8'h00;
    end
  end

  assign push_o      = accept && !done_q;
  assign push_word_o = (first_blk && (wib_q == CRC_WORD)) ? crc_q : masked;

  always_comb begin
    wib_d  = wib_q;
    blk_d  = blk_q;
    crc_d  = crc_q;
    done_d = done_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (busy_q) begin
      crc_d = crc_byte(crc_q, hold_q[8*idx_q +: 8]);
      idx_d = idx_q + 1'b1;
      if (idx_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end else if (push_o) begin
      if (first_blk && (wib_q != CRC_WORD)) begin
        crc_d  = crc_byte(crc_q, masked[7:0]);
        idx_d  = 2'd1;
        busy_d = 1'b1;
      end
      if (wib_q == LAST_PAYLOAD) begin
        wib_d = '0;
        if (last_blk) begin
          done_d = 1'b1;
        end else begin
          blk_d = blk_q + 1'b1;
        end
      end else begin
        wib_d = wib_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wib_q  <= '0;
      blk_q  <= '0;
      crc_q  <= CRC_INIT;
      done_q <= 1'b0;
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      wib_q  <= wib_d;
      blk_q  <= blk_d;
      crc_q  <= crc_d;
      done_q <= done_d;
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      hold_q <= masked;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ufbf_back.sv */
`default_nettype none

module ufbf_back
  import ufbf_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF,
  localparam int unsigned BLOCKS_MAX = (MAX_IMAGE_BYTES + 255) / 256,
  localparam int unsigned CNT_W      = $clog2(BLOCKS_MAX + 1),
  localparam int unsigned BN_W       = (BLOCKS_MAX > 1) ? $clog2(BLOCKS_MAX) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  output logic                  pop_o,
  input  wire logic [31:0]      pop_word_i,
  input  fifo_status_t          fifo_i,
  input  wire logic [CNT_W-1:0] blocks_i,
  input  wire logic [31:0]      base_address_i,
  input  wire logic [31:0]      family_id_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [31:0]           out_word_o,
  output logic                  end_of_block_o,
  output logic                  end_of_image_o
);

  back_state_e     state_q, state_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [5:0]      wib_q, wib_d;
  logic [BN_W-1:0] blk_q, blk_d;
  logic            ov_q;
  logic [31:0]     word_q;
  logic            eob_q, eoi_q;

  logic        load;
  logic        emit;
  logic [31:0] word_n;
  logic        eob_n, eoi_n;
  logic        last_blk;
  logic [31:0] head_word;

  assign load     = !ov_q || out_ready_i;
  assign last_blk = ((CNT_W + 1)'(blk_q) + 1'b1) >= (CNT_W + 1)'(blocks_i);

  always_comb begin
    case (cnt_q[2:0])
      3'd0:    head_word = MAGIC_START0;
      3'd1:    head_word = MAGIC_START1;
      3'd2:    head_word = FLAGS_FAMILY;
      3'd3:    head_word = base_address_i + 32'({blk_q, 8'h00});
      3'd4:    head_word = PAYLOAD_SIZE;
      3'd5:    head_word = 32'(blk_q);
      3'd6:    head_word = 32'(blocks_i);
      default: head_word = family_id_i;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    wib_d   = wib_q;
    blk_d   = blk_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    word_n  = '0;
    eob_n   = 1'b0;
    eoi_n   = 1'b0;
    case (state_q)
      BK_HEAD: begin
        if (load && !fifo_i.empty) begin
          emit   = 1'b1;
          word_n = head_word;
          if (cnt_q == LAST_HEADER) begin
            cnt_d   = '0;
            state_d = BK_PAY;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      BK_PAY: begin
        if (load && !fifo_i.empty) begin
          emit   = 1'b1;
          pop_o  = 1'b1;
          word_n = pop_word_i;
          if (wib_q == LAST_PAYLOAD) begin
            wib_d   = '0;
            cnt_d   = '0;
            state_d = BK_FILL;
          end else begin
            wib_d = wib_q + 1'b1;
          end
        end
      end
      BK_FILL: begin
        if (load) begin
          emit = 1'b1;
          if (cnt_q == LAST_FILL) begin
            cnt_d   = '0;
            state_d = BK_END;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      BK_END: begin
        if (load) begin
          emit   = 1'b1;
          word_n = MAGIC_END;
          eob_n  = 1'b1;
          eoi_n  = last_blk;
          if (last_blk) begin
            state_d = BK_DONE;
          end else begin
            blk_d   = blk_q + 1'b1;
            state_d = BK_HEAD;
          end
        end
      end
      BK_DONE: begin
        state_d = BK_DONE;
      end
      default: begin
        state_d = BK_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_HEAD;
      cnt_q   <= '0;
      wib_q   <= '0;
      blk_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wib_q   <= wib_d;
      blk_q   <= blk_d;
      if (load) begin
        ov_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && emit) begin
      word_q <= word_n;
      eob_q  <= eob_n;
      eoi_q  <= eoi_n;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_word_o     = word_q;
  assign end_of_block_o = eob_q;
  assign end_of_image_o = eoi_q;

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
  import ufbf_pkg::*;

  localparam int unsigned MAX_LEN = 65536;
  localparam logic [31:0] UF2_MAGIC0 = 32'h0A32_4655;
  localparam logic [31:0] UF2_MAGIC1 = 32'h9E5D_5157;
  localparam logic [31:0] UF2_FLAGS = 32'h0000_2000;
  localparam logic [31:0] UF2_PAYLOAD = 32'h0000_0100;
  localparam logic [31:0] UF2_MAGIC_END = 32'h0AB1_6F30;
  localparam logic [31:0] CRC32_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC32_SEED = 32'hFFFF_FFFF;
  localparam int unsigned LAST_WORD = 63;
  localparam int unsigned FILL_WORDS = 55;
  localparam int unsigned BLOCKS_RUN = 5;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] word;
    logic        eob;
    logic        eoi;
  } uf2_word_t;

  typedef struct packed {
    logic [31:0] image;
    logic [31:0] payload;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] image_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] out_word_o;
  logic        end_of_block_o;
  logic        end_of_image_o;

  logic [16:0] len_reg;
  logic [31:0] base_reg;
  logic [31:0] family_reg;
  logic [5:0]  pay_idx;
  logic [7:0]  blk_no;
  logic [31:0] crc_acc;
  bit          img_done;

  uf2_word_t   uf2_q[$];
  int unsigned errors;
  int unsigned cycles;
  bit          idle_on;
  bit          hold_req;

  dir_row_t directed [0:19] = '{
    '{32'h0000_0000, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h0000_0001, 32'h0000_0001},
    '{32'h8000_0000, 32'h8000_0000},
    '{32'h0000_00FF, 32'h0000_00FF},
    '{32'hFF00_0000, 32'hFF00_0000},
    '{32'h00FF_FF00, 32'h00FF_FF00},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFE},
    '{32'hA5A5_A5A5, 32'hA5A5_A5A5},
    '{32'h5A5A_5A5A, 32'h5A5A_5A5A},
    '{32'h1234_5678, 32'h1234_5678},
    '{32'h8765_4321, 32'h8765_4321},
    '{32'hDEAD_BEEF, 32'hDEAD_BEEF},
    '{32'h0F0F_0F0F, 32'h0F0F_0F0F},
    '{32'hF0F0_F0F0, 32'hF0F0_F0F0},
    '{32'h0A32_4655, 32'h0A32_4655},
    '{32'h0AB1_6F30, 32'h0AB1_6F30},
    '{32'h0101_0101, 32'h0101_0101},
    '{32'h8080_8080, 32'h8080_8080}
  };

  uf2_block_framer_with_boot_crc #(
    .MAX_IMAGE_BYTES(MAX_LEN)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .image_word_i  (image_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_o    (out_word_o),
    .end_of_block_o(end_of_block_o),
    .end_of_image_o(end_of_image_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  function automatic logic [31:0] next_crc(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      r = (r[31] ^ b[i]) ? ((r << 1) ^ CRC32_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic void put_word(input logic [31:0] w, input logic eob, input logic eoi);
    uf2_word_t e;
    e.word = w;
    e.eob = eob;
    e.eoi = eoi;
    uf2_q.push_back(e);
  endfunction

  task automatic frame_word(input logic [31:0] raw);
    int unsigned len;
    int unsigned nblk;
    int unsigned byte0;
    logic [31:0] w;
    bit last;
    if (!img_done) begin
      len = (len_reg == '0) ? 1 : ((len_reg > MAX_LEN) ? MAX_LEN : len_reg);
      nblk = (len + 255) / 256;
      w = raw;
      byte0 = blk_no * 256 + pay_idx * 4;
      for (int k = 0; k < 4; k++) begin
        if (byte0 + k >= len) begin
          w[8*k +: 8] = 8'h00;
        end
      end
      if (blk_no == 0 && pay_idx < LAST_WORD) begin
        for (int k = 0; k < 4; k++) begin
          crc_acc = next_crc(crc_acc, w[8*k +: 8]);
        end
      end else if (blk_no == 0) begin
        w = crc_acc;
      end
      if (pay_idx == 0) begin
        put_word(UF2_MAGIC0, 1'b0, 1'b0);
        put_word(UF2_MAGIC1, 1'b0, 1'b0);
        put_word(UF2_FLAGS, 1'b0, 1'b0);
        put_word(base_reg + 32'(blk_no) * 32'd256, 1'b0, 1'b0);
        put_word(UF2_PAYLOAD, 1'b0, 1'b0);
        put_word({24'h000000, blk_no}, 1'b0, 1'b0);
        put_word(32'(nblk), 1'b0, 1'b0);
        put_word(family_reg, 1'b0, 1'b0);
      end
      put_word(w, 1'b0, 1'b0);
      if (pay_idx == LAST_WORD) begin
        last = (blk_no + 1 >= nblk);
        repeat (FILL_WORDS) put_word(32'h0000_0000, 1'b0, 1'b0);
        put_word(UF2_MAGIC_END, 1'b1, last);
        pay_idx = '0;
        blk_no++;
        img_done = last;
      end else begin
        pay_idx++;
      end
    end
  endtask

  task automatic send_word(input logic [31:0] w);
    if (idle_on && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    image_word_i <= w;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    frame_word(w);
  endtask

  task automatic await_frames();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (uf2_q.size() != 0);
  endtask

  task automatic apb_access(input reg_idx_e idx, input bit wr, input logic [31:0] data,
                            output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx, input logic [31:0] exp);
    logic [31:0] rd;
    apb_access(idx, 1'b0, 32'h0, rd);
    if (rd !== exp) begin
      log_error($sformatf("register %s read %h, expected %h", idx.name(), rd, exp));
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_access(idx, 1'b1, val, rd);
    case (idx)
      REG_IMAGE_BYTES: begin
        len_reg = val[16:0];
        check_reg(idx, {15'h0, val[16:0]});
      end
      REG_BASE_ADDRESS: begin
        base_reg = val;
        check_reg(idx, val);
      end
      default: begin
        family_reg = val;
        check_reg(idx, val);
      end
    endcase
  endtask

  function automatic logic [31:0] rand_image();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) begin
      return 32'h0000_0000;
    end else if (sel == 1) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom();
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < 18);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    uf2_word_t got;
    uf2_word_t exp;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      got.word = out_word_o;
      got.eob = end_of_block_o;
      got.eoi = end_of_image_o;
      if (uf2_q.size() == 0) begin
        log_error($sformatf("unexpected word %h eob %b eoi %b", got.word, got.eob, got.eoi));
      end else begin
        exp = uf2_q.pop_front();
        if (got !== exp) begin
          log_error($sformatf("word %h eob %b eoi %b, expected %h eob %b eoi %b",
                              got.word, got.eob, got.eoi, exp.word, exp.eob, exp.eoi));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    image_word_i = '0;
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    len_reg = 17'h1_0000;
    base_reg = 32'h1000_0000;
    family_reg = 32'hE48B_FF56;
    pay_idx = '0;
    blk_no = '0;
    crc_acc = CRC32_SEED;
    img_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_reg(REG_IMAGE_BYTES, 32'h0001_0000);
    check_reg(REG_BASE_ADDRESS, 32'h1000_0000);
    check_reg(REG_FAMILY_ID, 32'hE48B_FF56);

    // Block 0 runs on the reset settings, so each directed word comes back unchanged.
    for (int i = 0; i < 20; i++) begin
      send_word(directed[i].image);
      uf2_q[$].word = directed[i].payload;
    end
    for (int i = 20; i < 64; i++) begin
      send_word(rand_image());
    end
    await_frames();

    for (int b = 1; b < BLOCKS_RUN; b++) begin
      case (b)
        1: begin
          write_reg(REG_IMAGE_BYTES, 32'h0001_FFFF);
          write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
          write_reg(REG_FAMILY_ID, 32'h0000_0000);
        end
        2: begin
          write_reg(REG_IMAGE_BYTES, 32'h0001_0000);
          write_reg(REG_BASE_ADDRESS, 32'h0000_0000);
          write_reg(REG_FAMILY_ID, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(REG_IMAGE_BYTES, $urandom_range(131071, 1025));
          write_reg(REG_BASE_ADDRESS, $urandom());
          write_reg(REG_FAMILY_ID, $urandom());
          idle_on = 1'b0;
        end
        default: begin
          // The final block: a single byte long (zero clamps to one) or ending within or at the end of this block.
          pick = $urandom_range(3);
          if (pick == 0) begin
            write_reg(REG_IMAGE_BYTES, 32'h0000_0000);
          end else if (pick == 1) begin
            write_reg(REG_IMAGE_BYTES, 32'h0000_0001);
          end else begin
            write_reg(REG_IMAGE_BYTES, 1024 + $urandom_range(256, 1));
          end
          idle_on = 1'b1;
        end
      endcase
      for (int i = 0; i < 64; i++) begin
        if (b == 1 && i == 8) begin
          hold_req = 1'b1;
        end
        send_word(rand_image());
      end
      await_frames();
    end

    for (int i = 0; i < 6; i++) begin
      send_word(rand_image());
    end
    await_frames();
    repeat (24) @(posedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
